/* design/sjf_pkg.sv */
// ----------------------------------------------------------------------------
// sjf_pkg: shared types for the shortest-job-first wait scheduler
// Holds the fixed field widths and the selection record passed from the
// compare unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sjf_pkg;

  localparam int unsigned TIME_W = 32;  // arrival time and run length
  localparam int unsigned WAIT_W = 63;  // saturating total

  // Job word in the table: {done, run length, arrival}
  localparam int unsigned JOB_W  = 2 * TIME_W + 1;

  typedef struct packed {
    logic              found;     // an arrived, unfinished job was seen
    logic [TIME_W-1:0] best_arr;  // arrival of the current best job
    logic [TIME_W-1:0] best_len;  // run length of the current best job
    logic [TIME_W-1:0] earliest;  // earliest arrival among unfinished jobs
  } sel_t;

endpackage : sjf_pkg

`default_nettype wire

/* design/sjf_ram.sv */
// ----------------------------------------------------------------------------
// sjf_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : sjf_ram

`default_nettype wire

/* design/sjf_pick.sv */
// ----------------------------------------------------------------------------
// sjf_pick: shared compare unit for the table scan
// Takes one table word per cycle and keeps the best ready job (shortest run,
// then earliest arrival, then lowest slot) and the earliest pending arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_pick #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CLK_W = 43
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clr_i,
  input  wire logic                      valid_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  input  wire logic [sjf_pkg::JOB_W-1:0] job_i,
  input  wire logic [CLK_W-1:0]          clock_i,
  output sjf_pkg::sel_t                  sel_o,
  output logic      [IDX_W-1:0]          best_idx_o
);

  sjf_pkg::sel_t                 sel_q, sel_d;
  logic [IDX_W-1:0]              best_idx_q, best_idx_d;
  logic [sjf_pkg::TIME_W-1:0]    arr, len;
  logic                          done, ready, better;

  assign arr  = job_i[sjf_pkg::TIME_W-1:0];
  assign len  = job_i[2*sjf_pkg::TIME_W-1:sjf_pkg::TIME_W];
  assign done = job_i[sjf_pkg::JOB_W-1];

  assign ready  = (CLK_W'(arr) <= clock_i);
  assign better = !sel_q.found || (len < sel_q.best_len) ||
                  ((len == sel_q.best_len) && (arr < sel_q.best_arr));

  always_comb begin
    sel_d      = sel_q;
    best_idx_d = best_idx_q;
    if (clr_i) begin
      sel_d.found    = 1'b0;
      sel_d.earliest = '1;
    end else if (valid_i && !done) begin
      if (arr < sel_q.earliest) begin
        sel_d.earliest = arr;
      end
      // strict compare keeps the lower slot on a full tie
      if (ready && better) begin
        sel_d.found    = 1'b1;
        sel_d.best_arr = arr;
        sel_d.best_len = len;
        best_idx_d     = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= '{found: 1'b0, best_arr: '0, best_len: '0, earliest: '1};
      best_idx_q <= '0;
    end else begin
      sel_q      <= sel_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign sel_o      = sel_q;
  assign best_idx_o = best_idx_q;

endmodule : sjf_pick

`default_nettype wire

/* design/sjf_total_wait_scheduler.sv */
// ----------------------------------------------------------------------------
// sjf_total_wait_scheduler: non-preemptive shortest-job-first total wait
// Loads jobs into a table and reports the summed waiting time of the set.
// ----------------------------------------------------------------------------
// Usage:
//   Slave beats carry one job each: tdata = {run length, arrival}, tlast
//   marks the final job of a set. Jobs load at one beat per cycle. Jobs
//   beyond MAX_JOBS are dropped and flag overflow on the result.
//   After the tlast beat the block stops taking beats and schedules: each
//   decision round scans the n stored jobs through the single read port of
//   the job table and one compare unit, then decides, and accumulates the
//   wait when a job is picked. Up to n picks and n time jumps are needed.
//   The master beat carries the saturating total in tdata and overflow in
//   tuser. The result sits in an output register, so loading of the next
//   set starts at once; a new result waits while the receiver stalls.
//   Reset empties the table (by job count) and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_total_wait_scheduler #(
  parameter int unsigned MAX_JOBS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] arrival_time, [63:32] run_length
  input  wire logic        s_axis_tlast,   // last_job
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,   // [62:0] total_wait, [63] zero
  output logic             m_axis_tuser    // overflow
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned CLK_W = sjf_pkg::TIME_W + 1 + IDX_W;
  localparam int unsigned TW    = sjf_pkg::TIME_W;
  localparam int unsigned WW    = sjf_pkg::WAIT_W;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_ACC    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ridx_q;
  logic             rvalid_q;
  logic             ovf_q, ovf_d;
  logic [CLK_W-1:0] clock_q, clock_d;
  logic [CLK_W-1:0] wait_q, wait_d;
  logic [WW-1:0]    sum_q, sum_d;
  logic             mvalid_q, mvalid_d;
  logic [WW-1:0]    mwait_q, mwait_d;
  logic             movf_q, movf_d;

  logic                      s_beat, full, last_idx, pick_clr;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [sjf_pkg::JOB_W-1:0] wdata, rdata;
  logic [WW:0]               sum_ext;
  logic [CNT_W-1:0]          count_m1;
  sjf_pkg::sel_t             sel;
  logic [IDX_W-1:0]          best_idx;

  assign s_axis_tready = (state_q == S_LOAD);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(MAX_JOBS));
  assign count_m1      = count_q - CNT_W'(1);
  assign last_idx      = (CNT_W'(idx_q) == count_m1);
  assign pick_clr      = (state_q == S_LOAD) || (state_q == S_DECIDE);
  assign sum_ext       = {1'b0, sum_q} + (WW + 1)'(wait_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    left_d   = left_q;
    idx_d    = idx_q;
    ovf_d    = ovf_q;
    clock_d  = clock_q;
    wait_d   = wait_q;
    sum_d    = sum_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    mwait_d  = mwait_q;
    movf_d   = movf_q;
    we       = 1'b0;
    waddr    = count_q[IDX_W-1:0];
    wdata    = {1'b0, s_axis_tdata[2*TW-1:TW], s_axis_tdata[TW-1:0]};

    case (state_q)
      S_LOAD: begin
        if (s_beat) begin
          if (!full) begin
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            left_d  = full ? count_q : count_q + CNT_W'(1);
            idx_d   = '0;
            clock_d = '0;
            sum_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        idx_d = '0;
        if (sel.found) begin
          // run the pick to completion and mark it done
          wait_d  = clock_q - CLK_W'(sel.best_arr);
          clock_d = clock_q + CLK_W'(sel.best_len);
          left_d  = left_q - CNT_W'(1);
          we      = 1'b1;
          waddr   = best_idx;
          wdata   = {1'b1, sel.best_len, sel.best_arr};
          state_d = S_ACC;
        end else begin
          // nothing ready: jump to the earliest pending arrival
          clock_d = CLK_W'(sel.earliest);
          state_d = S_SCAN;
        end
      end
      S_ACC: begin
        sum_d   = sum_ext[WW] ? '1 : sum_ext[WW-1:0];
        state_d = (left_q == '0) ? S_OUT : S_SCAN;
      end
      S_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mwait_d  = sum_q;
          movf_d   = ovf_q;
          count_d  = '0;
          ovf_d    = 1'b0;
          state_d  = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      count_q  <= '0;
      left_q   <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      rvalid_q <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      rvalid_q <= (state_q == S_SCAN);
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= idx_q;
    clock_q <= clock_d;
    wait_q  <= wait_d;
    sum_q   <= sum_d;
    mwait_q <= mwait_d;
    movf_q  <= movf_d;
  end

  sjf_ram #(
    .WIDTH (sjf_pkg::JOB_W),
    .DEPTH (1 << IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  sjf_pick #(
    .IDX_W (IDX_W),
    .CLK_W (CLK_W)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (pick_clr),
    .valid_i    (rvalid_q),
    .idx_i      (ridx_q),
    .job_i      (rdata),
    .clock_i    (clock_q),
    .sel_o      (sel),
    .best_idx_o (best_idx)
  );

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {1'b0, mwait_q};
  assign m_axis_tuser  = movf_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond table size");

  a_left_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (left_q <= count_q))
    else $error("remaining jobs exceed stored jobs");

  a_scan_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q))
    else $error("scan beyond stored jobs");

  a_pick_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && sel.found) |=> (state_q == S_ACC))
    else $error("pick not accumulated");

endmodule : sjf_total_wait_scheduler

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the shortest-job-first total wait scheduler
// Streams job sets into the block and keeps its own table and scheduler
// alongside. Each result beat is checked field by field against the oldest
// predicted total. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned     JOB_CAP      = 1024;
  localparam longint unsigned WAIT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned     HOLD_CYCLES  = 3000;
  localparam int unsigned     DRAIN_CYCLES = 200;
  localparam int unsigned     RANDOM_ITEMS = 560;
  localparam longint unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned     TW           = sjf_pkg::TIME_W;
  localparam int unsigned     WW           = sjf_pkg::WAIT_W;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;
  typedef enum int unsigned {VAL_TINY, VAL_SPREAD, VAL_FULL, VAL_EXTREME} val_mode_e;

  typedef struct packed {
    logic [WW-1:0] total_wait;
    logic          overflow;
  } sched_result_t;

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [2*TW-1:0] s_axis_tdata  = '0;  // [31:0] arrival_time, [63:32] run_length
  logic            s_axis_tlast  = 1'b0; // last_job
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [63:0]     m_axis_tdata;         // [62:0] total_wait, [63] zero
  logic            m_axis_tuser;         // overflow

  // Shadow job table for the set being loaded
  logic [TW-1:0]     set_arrival [JOB_CAP];
  logic [TW-1:0]     set_length  [JOB_CAP];
  int unsigned       set_count   = 0;
  bit                set_dropped = 1'b0;

  sched_result_t     pending_totals [$];
  bit                failed      = 1'b0;
  int unsigned       burst_left  = 0;
  int unsigned       gap_max     = 0;
  int unsigned       burst_max   = 1;
  int unsigned       hold_reqs   = 0;
  int unsigned       items_sent  = 0;
  longint unsigned   cycle_count = 0;

  sjf_total_wait_scheduler #(
    .MAX_JOBS(JOB_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Non-preemptive SJF over the shadow table, ties to earlier arrival then lower slot
  function automatic logic [WW-1:0] schedule_wait();
    bit              done [JOB_CAP];
    longint unsigned now, sum, earliest, w;
    int unsigned     left, pick, i;
    bit              found;
    for (i = 0; i < JOB_CAP; i++) done[i] = 1'b0;
    now  = 0;
    sum  = 0;
    pick = 0;
    left = set_count;
    while (left != 0) begin
      found    = 1'b0;
      earliest = '1;
      for (i = 0; i < set_count; i++) begin
        if (!done[i]) begin
          if (set_arrival[i] < earliest) earliest = set_arrival[i];
          if (set_arrival[i] <= now &&
              (!found || set_length[i] < set_length[pick] ||
               (set_length[i] == set_length[pick] &&
                set_arrival[i] < set_arrival[pick]))) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        // nothing ready: jump to the next arrival
        now = earliest;
      end else begin
        w    = now - set_arrival[pick];
        sum  = (w > WAIT_MAX - sum) ? WAIT_MAX : sum + w;
        now += set_length[pick];
        done[pick] = 1'b1;
        left--;
      end
    end
    return sum[WW-1:0];
  endfunction

  function automatic void note_job(logic [TW-1:0] arr, logic [TW-1:0] len,
                                   bit last);
    sched_result_t r;
    items_sent++;
    if (set_count < JOB_CAP) begin
      set_arrival[set_count] = arr;
      set_length[set_count]  = len;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      r.total_wait = schedule_wait();
      r.overflow   = set_dropped;
      pending_totals.insert(pending_totals.size(), r);
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endfunction

  function automatic logic [TW-1:0] pick_value(val_mode_e m, bit is_len);
    case (m)
      VAL_TINY:   return is_len ? $urandom_range(7, 0) : $urandom_range(15, 0);
      VAL_SPREAD: return is_len ? $urandom_range(300, 0) : $urandom_range(1000, 0);
      VAL_FULL:   return $urandom();
      default: begin
        case ($urandom_range(4, 0))
          0:       return '0;
          1:       return 1;
          2:       return {TW{1'b1}} - 1'b1;
          3:       return '1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Offer one job and hold it until taken; gaps fall between random bursts
  task automatic send_job(logic [TW-1:0] arr, logic [TW-1:0] len, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom(), $urandom()};
        s_axis_tlast  <= 1'($urandom_range(1, 0));
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, arr};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    note_job(arr, len, last);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic send_set(int unsigned n, val_mode_e m);
    int unsigned k;
    for (k = 0; k < n; k++) send_job(pick_value(m, 1'b0), pick_value(m, 1'b1), k == n - 1);
  endtask

  task automatic test_single_jobs();
    gap_max   = 2;
    burst_max = 3;
    send_job('0, '0, 1'b1);
    send_job('1, '1, 1'b1);
    send_job(7, 3, 1'b1);
    stop_sending();
  endtask

  task automatic test_tie_breaks();
    // equal length: earlier arrival first
    send_job(4, 5, 1'b0);
    send_job(2, 5, 1'b0);
    send_job(0, 9, 1'b1);
    // equal length and arrival: lower slot first
    send_job(3, 6, 1'b0);
    send_job(3, 6, 1'b0);
    send_job(0, 1, 1'b1);
    stop_sending();
  endtask

  task automatic test_idle_jumps();
    send_job(100, 5, 1'b0);
    send_job(10, 50, 1'b0);
    send_job(200, 1, 1'b0);
    send_job(300, 0, 1'b1);
    stop_sending();
  endtask

  task automatic test_field_extremes();
    send_job('1, '1, 1'b0);
    send_job('0, '1, 1'b0);
    send_job(1, '1, 1'b0);
    send_job('1, '0, 1'b0);
    send_job('0, '0, 1'b1);
    stop_sending();
  endtask

  // Fill the table, then drop one ordinary job and the last job
  task automatic test_table_overflow();
    int unsigned k;
    gap_max   = 1;
    burst_max = 64;
    for (k = 0; k < JOB_CAP + 2; k++)
      send_job($urandom_range(3, 0), $urandom(), k == JOB_CAP + 1);
    stop_sending();
  endtask

  // Receiver holds off while small sets keep coming, so the input backs up
  task automatic test_backpressure();
    int unsigned k;
    gap_max   = 0;
    burst_max = 1;
    hold_reqs++;
    for (k = 0; k < 40; k++) send_set($urandom_range(2, 1), VAL_SPREAD);
    stop_sending();
  endtask

  task automatic test_random_sets();
    int unsigned stop_at, n, r;
    val_mode_e   m;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(99, 0);
      n = (r < 60) ? $urandom_range(4, 1) : (r < 90) ? $urandom_range(12, 5)
                                                     : $urandom_range(48, 13);
      m = val_mode_e'($urandom_range(3, 0));
      case ($urandom_range(4, 0))
        0, 1:    gap_max = 0;
        2:       gap_max = 1;
        3:       gap_max = 3;
        default: gap_max = 10;
      endcase
      burst_max = ($urandom_range(1, 0) != 0) ? $urandom_range(16, 1) : 1;
      send_set(n, m);
    end
    stop_sending();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_jobs();
    test_tie_breaks();
    test_idle_jumps();
    test_field_extremes();
    test_table_overflow();
    test_backpressure();
    test_random_sets();
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned phase_left, hold_left, hold_taken;
    mode       = RX_ALWAYS;
    phase_left = 0;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_taken != hold_reqs) begin
        hold_taken = hold_reqs;
        hold_left  = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = rx_mode_e'($urandom_range(3, 0));
          phase_left = $urandom_range(400, 20);
        end
        phase_left--;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(1, 0));
          RX_SPARSE: m_axis_tready <= ($urandom_range(7, 0) == 0);
          default:   m_axis_tready <= (phase_left % 8) < 3;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_totals.size() == 0) begin
        $error("result beat with none pending: total_wait %0d, overflow %b",
               m_axis_tdata[WW-1:0], m_axis_tuser);
        failed = 1'b1;
      end else begin
        want = pending_totals.pop_front();
        if (m_axis_tdata[WW-1:0] !== want.total_wait) begin
          $error("total_wait: expected %0d, actual %0d", want.total_wait,
                 m_axis_tdata[WW-1:0]);
          failed = 1'b1;
        end
        if (m_axis_tuser !== want.overflow) begin
          $error("overflow: expected %b, actual %b", want.overflow, m_axis_tuser);
          failed = 1'b1;
        end
        if (m_axis_tdata[63] !== 1'b0) begin
          $error("tdata pad: expected 0, actual %b", m_axis_tdata[63]);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

endmodule
